>>> rtl/core/hsr_pkg.sv
package hsr_pkg;

	// Replacement name limits.
	localparam int NAME_MAX   = 16;
	localparam int NAME_BYTES = 16;
	localparam int NAME_CAP   = (NAME_MAX < NAME_BYTES) ? NAME_MAX : NAME_BYTES;
	localparam int NAME_LEN_W = 5;

	// Configuration port geometry.
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 2;

	// Default depth of the command queue between front and back.
	localparam int QUEUE_DEPTH_DEF = 4;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_NAME_LENGTH = 2'd0,
		REG_NAME_LOW    = 2'd1,
		REG_NAME_HIGH   = 2'd2
	} reg_index_t;

	// One beat of the response stream.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       chunk_first;
		logic       in_header;
	} in_beat_t;

	// One beat of the rewritten stream.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
	} out_beat_t;

	// Work handed from the classifier to the emitter: the byte itself,
	// optionally preceded by the replacement name.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_name;
	} cmd_t;

endpackage

>>> rtl/core/hsr_stream_if.sv
interface hsr_stream_if #(
	parameter type payload_t = logic
) ();

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

>>> rtl/core/http_server_header_rewriter_core.sv
// A taken beat is written into the command queue and then into the output register
// before it is shown. One response byte per cycle while the queue has room and the
// output is ready; a rewritten Server line holds the emitter while its name is sent.
// The command queue absorbs the stall so input keeps flowing while it has room.
// Reset clears line tracking, queue pointers, output valid and the name registers.
module http_server_header_rewriter_core #(
	parameter int QUEUE_DEPTH = hsr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [hsr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [hsr_pkg::CFG_DATA_W-1:0]  cfg_data,
	hsr_stream_if.sink                      resp,
	hsr_stream_if.source                    rewritten
);

	logic [hsr_pkg::NAME_LEN_W-1:0] name_length_q;
	logic [hsr_pkg::CFG_DATA_W-1:0] name_low_q;
	logic [hsr_pkg::CFG_DATA_W-1:0] name_high_q;
	logic [hsr_pkg::NAME_LEN_W-1:0] name_len_eff;

	logic          q_push;
	logic          q_pop;
	logic          q_empty;
	logic          q_full;
	hsr_pkg::cmd_t q_cmd;
	hsr_pkg::cmd_t q_head;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_length_q <= '0;
			name_low_q    <= '0;
			name_high_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hsr_pkg::REG_NAME_LENGTH: name_length_q <= cfg_data[hsr_pkg::NAME_LEN_W-1:0];
				hsr_pkg::REG_NAME_LOW:    name_low_q    <= cfg_data;
				hsr_pkg::REG_NAME_HIGH:   name_high_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Inserted name length, capped at the name storage.
	assign name_len_eff = (name_length_q > hsr_pkg::NAME_LEN_W'(hsr_pkg::NAME_CAP)) ?
		hsr_pkg::NAME_LEN_W'(hsr_pkg::NAME_CAP) : name_length_q;

	hsr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.resp   (resp),
		.q_full (q_full),
		.q_push (q_push),
		.q_cmd  (q_cmd)
	);

	hsr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty),
		.full     (q_full)
	);

	hsr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.empty      (q_empty),
		.pop        (q_pop),
		.name_len   (name_len_eff),
		.name_bytes ({name_high_q, name_low_q}),
		.rewritten  (rewritten)
	);

	// The classifier never writes into a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) !(q_push && q_full))
		else $error("command queue overflow");

	// The emitter never retires a command that is not there.
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> !q_empty)
		else $error("command queue underflow");

	// While a name byte waits at the output, its command stays queued.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rewritten.valid && !rewritten.payload.run_last) |-> !q_empty)
		else $error("name byte shown without its command");

endmodule

>>> rtl/core/hsr_front.sv
module hsr_front (
	input  logic          clk,
	input  logic          arst_n,
	hsr_stream_if.sink    resp,
	input  logic          q_full,
	output logic          q_push,
	output hsr_pkg::cmd_t q_cmd
);

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [2:0] TOKEN_LEN = 3'd7;

	typedef enum logic [1:0] {
		PH_SCAN,
		PH_MATCH,
		PH_AFTER,
		PH_DROP
	} phase_t;

	// Letters of the token, compared after folding to upper case.
	function automatic logic [7:0] token_char(input logic [2:0] pos);
		logic [7:0] c;
		unique case (pos)
			3'd0: c = 8'h53;
			3'd1: c = 8'h45;
			3'd2: c = 8'h52;
			3'd3: c = 8'h56;
			3'd4: c = 8'h45;
			3'd5: c = 8'h52;
			3'd6: c = 8'h3A;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] to_upper(input logic [7:0] b);
		logic [7:0] u;
		u = ((b >= 8'h61) && (b <= 8'h7A)) ? (b - 8'd32) : b;
		return u;
	endfunction

	phase_t     phase_q, phase_d, phase_in;
	logic       line_start_q, line_start_d, line_start_in;
	logic [2:0] tok_pos_q, tok_pos_d, tok_pos_in;

	logic [7:0] b;
	logic [7:0] ub;
	logic       eol;
	logic       cut;
	logic       emit;
	logic       has_name;
	logic       accept;

	assign b      = resp.payload.data_byte;
	assign ub     = to_upper(b);
	assign eol    = (b == CH_CR) || (b == CH_LF);
	assign accept = resp.valid && resp.ready;

	// A beat is taken whenever the queue has room.
	assign resp.ready = !q_full;

	// A pending name is flushed when the value is cut off by a new chunk
	// or by leaving the header.
	assign cut = (resp.payload.chunk_first || !resp.payload.in_header) &&
		((phase_q == PH_AFTER) || (phase_q == PH_DROP));

	// Line tracking and classification of the current beat.
	always_comb begin
		phase_in      = phase_q;
		line_start_in = line_start_q;
		tok_pos_in    = tok_pos_q;
		if (resp.payload.chunk_first) begin
			phase_in      = PH_SCAN;
			line_start_in = 1'b1;
			tok_pos_in    = '0;
		end

		phase_d      = phase_in;
		line_start_d = line_start_in;
		tok_pos_d    = tok_pos_in;
		emit         = 1'b1;
		has_name     = cut;

		if (!resp.payload.in_header) begin
			phase_d      = PH_SCAN;
			line_start_d = eol;
			tok_pos_d    = '0;
		end else begin
			unique case (phase_in)
				PH_SCAN: begin
					if (line_start_in && (ub == token_char(3'd0))) begin
						phase_d      = PH_MATCH;
						tok_pos_d    = 3'd1;
						line_start_d = 1'b0;
					end else begin
						line_start_d = eol;
					end
				end
				PH_MATCH: begin
					if ((tok_pos_in < TOKEN_LEN) && (ub == token_char(tok_pos_in))) begin
						if (tok_pos_in == TOKEN_LEN - 3'd1) begin
							phase_d   = PH_AFTER;
							tok_pos_d = '0;
						end else begin
							tok_pos_d = tok_pos_in + 3'd1;
						end
					end else begin
						phase_d      = PH_SCAN;
						tok_pos_d    = '0;
						line_start_d = eol;
					end
				end
				PH_AFTER: begin
					if (eol) begin
						has_name     = 1'b1;
						line_start_d = 1'b1;
						phase_d      = PH_SCAN;
					end else begin
						phase_d = PH_DROP;
					end
				end
				PH_DROP: begin
					if (eol) begin
						has_name     = 1'b1;
						line_start_d = 1'b1;
						phase_d      = PH_SCAN;
					end else begin
						emit = 1'b0;
					end
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

	assign q_push         = accept && emit;
	assign q_cmd.data_byte = b;
	assign q_cmd.has_name  = has_name;

	// Line tracking state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_SCAN;
			line_start_q <= 1'b1;
			tok_pos_q    <= '0;
		end else if (accept) begin
			phase_q      <= phase_d;
			line_start_q <= line_start_d;
			tok_pos_q    <= tok_pos_d;
		end
	end

endmodule

>>> rtl/core/hsr_queue.sv
module hsr_queue #(
	parameter int DEPTH = hsr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hsr_pkg::cmd_t push_cmd,
	input  logic          pop,
	output hsr_pkg::cmd_t head,
	output logic          empty,
	output logic          full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	hsr_pkg::cmd_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(DEPTH));
	assign head  = mem_q[rd_ptr_q];

	// Storage is written on push only.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> rtl/core/hsr_back.sv
module hsr_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  hsr_pkg::cmd_t                       head,
	input  logic                                empty,
	output logic                                pop,
	input  logic [hsr_pkg::NAME_LEN_W-1:0]      name_len,
	input  logic [8*hsr_pkg::NAME_BYTES-1:0]    name_bytes,
	hsr_stream_if.source                        rewritten
);

	logic                           out_valid_q;
	hsr_pkg::out_beat_t             out_beat_q;
	logic [hsr_pkg::NAME_LEN_W-1:0] idx_q;
	logic                           advance;
	logic                           name_pending;
	logic [7:0]                     name_byte;

	assign rewritten.valid   = out_valid_q;
	assign rewritten.payload = out_beat_q;

	// The output register takes a new beat when it is empty or being drained.
	assign advance      = !out_valid_q || rewritten.ready;
	assign name_pending = head.has_name && (idx_q < name_len);
	assign name_byte    = name_bytes[idx_q[3:0]*8 +: 8];
	assign pop          = advance && !empty && !name_pending;

	// Output beat payload.
	always_ff @(posedge clk) begin
		if (advance && !empty) begin
			if (name_pending) begin
				out_beat_q.out_byte <= name_byte;
				out_beat_q.run_last <= 1'b0;
			end else begin
				out_beat_q.out_byte <= head.data_byte;
				out_beat_q.run_last <= 1'b1;
			end
		end
	end

	// Output valid and name byte counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (advance) begin
			out_valid_q <= !empty;
			if (!empty) begin
				if (name_pending) begin
					idx_q <= idx_q + hsr_pkg::NAME_LEN_W'(1);
				end else begin
					idx_q <= '0;
				end
			end
		end
	end

endmodule
